// ===== hw/rtl/ncid_pkg.sv =====
// Shared types and codes for the NEW_CONNECTION_ID frame parser.
// No dependencies; every other file of the parser but ncid_if imports this package.
package ncid_pkg;

   localparam int VARINT_W = 62;

   // Result kinds.
   localparam logic [1:0] KIND_CID    = 2'd0;
   localparam logic [1:0] KIND_TOKEN  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // Finish status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_TRUNC  = 2'd1;
   localparam logic [1:0] STATUS_CIDLEN = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          data_out;
      logic [4:0]          byte_index;
      logic [1:0]          status;
      logic [VARINT_W-1:0] sequence_number;
      logic [VARINT_W-1:0] retire_prior;
      logic [4:0]          cid_length;
      logic [5:0]          consumed_length;
      logic                last_of_run;
   } rsp_item_type;

   // Which of the two result slots the parser fills for one input transaction.
   typedef struct packed {
      logic valid0;
      logic valid1;
   } push_type;

endpackage

// ===== hw/rtl/ncid_if.sv =====
// Valid/ready channel interfaces for the NEW_CONNECTION_ID frame parser.
// Depends on nothing; the payload widths follow the frame fields.
interface ncid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       buffer_end;

   modport source(output valid, data_in, buffer_end, input ready);
   modport sink(input valid, data_in, buffer_end, output ready);
endinterface

interface ncid_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_out;
   logic [4:0]  byte_index;
   logic [1:0]  status;
   logic [61:0] sequence_number;
   logic [61:0] retire_prior;
   logic [4:0]  cid_length;
   logic [5:0]  consumed_length;
   logic        last_of_run;

   modport source(output valid, kind, data_out, byte_index, status, sequence_number,
                  retire_prior, cid_length, consumed_length, last_of_run, input ready);
   modport sink(input valid, kind, data_out, byte_index, status, sequence_number,
                retire_prior, cid_length, consumed_length, last_of_run, output ready);
endinterface

// ===== hw/rtl/ncid_parse_core.sv =====
// Frame state registers and the per-byte decode logic of the parser.
// Depends on ncid_pkg; produces up to two results per accepted byte.
module ncid_parse_core #(
   parameter int MAX_CID_LEN = 20,
   parameter int TOKEN_LEN   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_in,
   input  logic                  buffer_end,
   output ncid_pkg::push_type     push,
   output ncid_pkg::rsp_item_type item0,
   output ncid_pkg::rsp_item_type item1
);
   import ncid_pkg::*;

   localparam int FIELD_MAX = (MAX_CID_LEN > TOKEN_LEN) ? MAX_CID_LEN : TOKEN_LEN;
   localparam int FC_W      = $clog2(FIELD_MAX + 1);
   localparam int ID_W      = $clog2(MAX_CID_LEN + 1);
   localparam logic [8:0] CID_LIMIT = 9'(MAX_CID_LEN);
   localparam logic [8:0] TOKEN_END = 9'(TOKEN_LEN);

   localparam logic [2:0] PH_TYPE   = 3'd0;
   localparam logic [2:0] PH_SEQ    = 3'd1;
   localparam logic [2:0] PH_RETIRE = 3'd2;
   localparam logic [2:0] PH_CIDLEN = 3'd3;
   localparam logic [2:0] PH_CID    = 3'd4;
   localparam logic [2:0] PH_TOKEN  = 3'd5;
   localparam logic [2:0] PH_SKIP   = 3'd6;

   logic [2:0]          phase_ff, phase_in;
   logic [2:0]          vleft_ff, vleft_in;
   logic [VARINT_W-1:0] vacc_ff, vacc_in;
   logic [VARINT_W-1:0] seq_ff, seq_in;
   logic [VARINT_W-1:0] retire_ff, retire_in;
   logic [ID_W-1:0]     id_len_ff, id_len_in;
   logic [FC_W-1:0]     fcount_ff, fcount_in;
   logic [5:0]          taken_ff, taken_in;

   logic                in_frame;
   logic [5:0]          taken_inc;
   logic [VARINT_W-1:0] acc_new;
   logic [2:0]          left_new;
   logic                vdone;
   logic [FC_W:0]       fc_plus;
   logic                byte_v, fin_v, finished;
   rsp_item_type        byte_item, fin_item;

   assign in_frame  = (phase_ff <= PH_TOKEN);
   assign taken_inc = (in_frame && taken_ff != 6'h3f) ? 6'(taken_ff + 6'd1) : taken_ff;
   assign fc_plus   = (FC_W + 1)'({1'b0, fcount_ff} + 1'b1);

   // Variable-length integer step: the first byte carries the length code.
   always_comb begin
      if (vleft_ff == 3'd0) begin
         acc_new = {56'd0, data_in[5:0]};
         unique case (data_in[7:6])
            2'd0:    left_new = 3'd0;
            2'd1:    left_new = 3'd1;
            2'd2:    left_new = 3'd3;
            default: left_new = 3'd7;
         endcase
      end else begin
         acc_new  = {vacc_ff[VARINT_W-9:0], data_in};
         left_new = vleft_ff - 3'd1;
      end
      vdone = (left_new == 3'd0);
   end

   always_comb begin
      phase_in  = phase_ff;
      vleft_in  = vleft_ff;
      vacc_in   = vacc_ff;
      seq_in    = seq_ff;
      retire_in = retire_ff;
      id_len_in = id_len_ff;
      fcount_in = fcount_ff;
      taken_in  = taken_inc;
      byte_v    = 1'b0;
      fin_v     = 1'b0;
      finished  = 1'b0;
      byte_item = '0;
      fin_item  = '0;

      unique case (phase_ff)
         PH_TYPE: begin
            seq_in    = '0;
            retire_in = '0;
            id_len_in = '0;
            fcount_in = '0;
            vleft_in  = '0;
            vacc_in   = '0;
            taken_in  = 6'd1;
            phase_in  = PH_SEQ;
         end
         PH_SEQ: begin
            vacc_in  = acc_new;
            vleft_in = left_new;
            if (vdone) begin
               seq_in   = acc_new;
               phase_in = PH_RETIRE;
            end
         end
         PH_RETIRE: begin
            vacc_in  = acc_new;
            vleft_in = left_new;
            if (vdone) begin
               retire_in = acc_new;
               phase_in  = PH_CIDLEN;
            end
         end
         PH_CIDLEN: begin
            if ({1'b0, data_in} > CID_LIMIT) begin
               fin_v                    = 1'b1;
               finished                 = 1'b1;
               fin_item.kind            = KIND_FINISH;
               fin_item.status          = STATUS_CIDLEN;
               fin_item.sequence_number = seq_ff;
               fin_item.retire_prior    = retire_ff;
               phase_in                 = buffer_end ? PH_TYPE : PH_SKIP;
            end else begin
               id_len_in = data_in[ID_W-1:0];
               fcount_in = '0;
               phase_in  = (data_in != 8'd0) ? PH_CID : PH_TOKEN;
            end
         end
         PH_CID: begin
            byte_v               = 1'b1;
            byte_item.kind       = KIND_CID;
            byte_item.data_out   = data_in;
            byte_item.byte_index = 5'(fcount_ff);
            fcount_in            = fc_plus[FC_W-1:0];
            if (9'(fc_plus) >= 9'(id_len_ff)) begin
               fcount_in = '0;
               phase_in  = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            byte_v               = 1'b1;
            byte_item.kind       = KIND_TOKEN;
            byte_item.data_out   = data_in;
            byte_item.byte_index = 5'(fcount_ff);
            fcount_in            = fc_plus[FC_W-1:0];
            if (9'(fc_plus) >= TOKEN_END) begin
               fin_v                    = 1'b1;
               finished                 = 1'b1;
               fin_item.kind            = KIND_FINISH;
               fin_item.status          = STATUS_OK;
               fin_item.sequence_number = seq_ff;
               fin_item.retire_prior    = retire_ff;
               fin_item.cid_length      = 5'(id_len_ff);
               fin_item.consumed_length = taken_inc;
               fcount_in                = '0;
               phase_in                 = buffer_end ? PH_TYPE : PH_SKIP;
            end
         end
         default: begin
            if (buffer_end) begin
               phase_in = PH_TYPE;
            end
         end
      endcase

      // Buffer ended before the frame was complete.
      if (buffer_end && in_frame && !finished) begin
         fin_v                    = 1'b1;
         fin_item                 = '0;
         fin_item.kind            = KIND_FINISH;
         fin_item.status          = STATUS_TRUNC;
         fin_item.sequence_number = seq_in;
         fin_item.retire_prior    = retire_in;
         fin_item.cid_length      = 5'(id_len_in);
         phase_in                 = PH_TYPE;
      end

      fin_item.last_of_run  = 1'b1;
      byte_item.last_of_run = !fin_v;
   end

   assign item0       = byte_v ? byte_item : fin_item;
   assign item1       = fin_item;
   assign push.valid0 = accept && (byte_v || fin_v);
   assign push.valid1 = accept && byte_v && fin_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         vleft_ff  <= '0;
         vacc_ff   <= '0;
         seq_ff    <= '0;
         retire_ff <= '0;
         id_len_ff <= '0;
         fcount_ff <= '0;
         taken_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         vleft_ff  <= vleft_in;
         vacc_ff   <= vacc_in;
         seq_ff    <= seq_in;
         retire_ff <= retire_in;
         id_len_ff <= id_len_in;
         fcount_ff <= fcount_in;
         taken_ff  <= taken_in;
      end
   end

endmodule

// ===== hw/rtl/ncid_out_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle and gives one while the reader is ready.
// Depends on ncid_pkg for the result item type and the push control struct.
module ncid_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  ncid_pkg::push_type     push,
   input  ncid_pkg::rsp_item_type item0,
   input  ncid_pkg::rsp_item_type item1,
   input  logic                  out_ready,
   output logic                  out_valid,
   output ncid_pkg::rsp_item_type out_item,
   output logic                  has_room
);
   import ncid_pkg::*;

   rsp_item_type mem_ff [4];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   count_ff;
   logic         pop;
   logic [2:0]   n_push;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign has_room  = (count_ff <= 3'd2);
   assign pop       = out_valid && out_ready;
   assign n_push    = 3'(push.valid0) + 3'(push.valid1);

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         mem_ff[wr_ptr_ff] <= item0;
      end
      if (push.valid1) begin
         mem_ff[2'(wr_ptr_ff + 2'd1)] <= item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= 2'(wr_ptr_ff + n_push[1:0]);
         rd_ptr_ff <= 2'(rd_ptr_ff + 2'(pop));
         count_ff  <= 3'(count_ff + n_push - 3'(pop));
      end
   end

endmodule

// ===== hw/rtl/quic_new_cid_frame_parser_unit.sv =====
// Results of a byte transaction are registered in the result queue before they are presented.
// Throughput: one byte per cycle; a token byte that finishes the frame, or a CID or token byte
// that ends the buffer, gives two results, drained at one per cycle while the receiver is ready,
// and byte intake stalls while three or more results wait in the queue.
// Reset: synchronous, active high; clears the frame state and empties the result queue.
// Depends on ncid_pkg, ncid_if, ncid_parse_core and ncid_out_fifo.
module quic_new_cid_frame_parser_unit #(
   parameter int MAX_CID_LEN = 20,
   parameter int TOKEN_LEN   = 16
) (
   input logic         clock,
   input logic         reset,
   ncid_req_if.sink    req_ch,
   ncid_rsp_if.source  rsp_ch
);
   import ncid_pkg::*;

   // A request transaction moves one frame byte. The core decodes it against the
   // registered frame state in the same cycle and writes zero, one or two results
   // into the output queue. Ready stays high while the queue has room for two
   // results, so the input side keeps streaming while earlier results wait.
   logic         accept;
   push_type     push;
   rsp_item_type item0, item1, out_item;
   logic         has_room;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = has_room;

   ncid_parse_core #(
      .MAX_CID_LEN(MAX_CID_LEN),
      .TOKEN_LEN  (TOKEN_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_in   (req_ch.data_in),
      .buffer_end(req_ch.buffer_end),
      .push      (push),
      .item0     (item0),
      .item1     (item1)
   );

   // The queue splits the two sides: a stalled result does not stop byte intake
   // until the queue can no longer absorb a two-result transaction.
   ncid_out_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item0    (item0),
      .item1    (item1),
      .out_ready(rsp_ch.ready),
      .out_valid(rsp_ch.valid),
      .out_item (out_item),
      .has_room (has_room)
   );

   assign rsp_ch.kind            = out_item.kind;
   assign rsp_ch.data_out        = out_item.data_out;
   assign rsp_ch.byte_index      = out_item.byte_index;
   assign rsp_ch.status          = out_item.status;
   assign rsp_ch.sequence_number = out_item.sequence_number;
   assign rsp_ch.retire_prior    = out_item.retire_prior;
   assign rsp_ch.cid_length      = out_item.cid_length;
   assign rsp_ch.consumed_length = out_item.consumed_length;
   assign rsp_ch.last_of_run     = out_item.last_of_run;

endmodule

// ===== hw/rtl/ncid_checker.sv =====
// Port-level checks for the NEW_CONNECTION_ID frame parser, bound to its top level.
// Depends on ncid_pkg for the result kind and status codes.
module ncid_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] kind,
   input logic [7:0] data_out,
   input logic [4:0] byte_index,
   input logic [1:0] status,
   input logic [5:0] consumed_length,
   input logic       last_of_run
);
   import ncid_pkg::*;

   // A stalled result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(data_out)
         && $stable(byte_index) && $stable(status) && $stable(last_of_run))
      else $error("stalled result changed");

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A finish result always closes the run of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_FINISH |-> last_of_run)
      else $error("finish result not last of run");

   // Byte results carry no status and no consumed count; a good finish has a count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != KIND_FINISH |-> status == STATUS_OK && consumed_length == 6'd0)
      else $error("byte result with finish fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_FINISH && status == STATUS_OK |-> consumed_length != 6'd0)
      else $error("good finish with zero length");

endmodule

bind quic_new_cid_frame_parser_unit ncid_checker u_ncid_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .kind           (rsp_ch.kind),
   .data_out       (rsp_ch.data_out),
   .byte_index     (rsp_ch.byte_index),
   .status         (rsp_ch.status),
   .consumed_length(rsp_ch.consumed_length),
   .last_of_run    (rsp_ch.last_of_run)
);
